// ===== hw/rtl/rep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rep_pkg: shared types and constants of the rotated ellipse point generator
// Request and result payloads, fixed-point formats, angle constants and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rep_pkg;

    // Configuration
    localparam int REP_CORDIC_ITERATIONS = 16;
    localparam int REP_CFG_W             = 10;
    localparam int REP_CFG_IDX_W         = 3;

    localparam logic [REP_CFG_IDX_W-1:0] REP_REG_CENTER_X   = 3'd0;
    localparam logic [REP_CFG_IDX_W-1:0] REP_REG_CENTER_Y   = 3'd1;
    localparam logic [REP_CFG_IDX_W-1:0] REP_REG_SEMI_A     = 3'd2;
    localparam logic [REP_CFG_IDX_W-1:0] REP_REG_SEMI_B     = 3'd3;
    localparam logic [REP_CFG_IDX_W-1:0] REP_REG_LINE_COLOR = 3'd4;
    localparam logic [REP_CFG_IDX_W-1:0] REP_REG_ROT_STEP   = 3'd5;

    // Field widths
    localparam int REP_CENTER_W = 10;
    localparam int REP_AXIS_W   = 9;
    localparam int REP_COLOR_W  = 4;
    localparam int REP_STEP_W   = 9;
    localparam int REP_ROT_W    = 9;
    localparam int REP_IDX_W    = 8;
    localparam int REP_PIX_W    = 12;

    // Angle handling, units of 1/360 degree
    localparam int REP_THETA_W       = 9;
    localparam int REP_RAW_W         = 20;
    localparam int REP_ANGLE_W       = 17;
    localparam int REP_DEG_UNITS     = 360;
    localparam int REP_FULL_TURN     = 129600;
    localparam int REP_HALF_TURN     = REP_FULL_TURN / 2;
    localparam int REP_QUARTER_TURN  = REP_FULL_TURN / 4;
    localparam int REP_THREE_QUARTER = 3 * REP_QUARTER_TURN;
    localparam int REP_UR_BIAS       = 4 * REP_FULL_TURN;
    localparam int REP_FIRST_SPAN    = 90;
    localparam int REP_INDEX_SKIP    = 180;

    // Degrees to Q3.28 radians: z = round(mag * PI_Q28 / HALF_TURN)
    localparam int          REP_PI_Q28     = 843314857;
    localparam int          REP_PI_QUOT    = REP_PI_Q28 / REP_HALF_TURN;
    localparam int          REP_PI_REM     = REP_PI_Q28 % REP_HALF_TURN;
    localparam int          REP_ROUND_HALF = REP_HALF_TURN / 2;
    localparam int          REP_DIV_SHIFT  = 5;
    localparam int          REP_DIV_ODD    = REP_HALF_TURN >> REP_DIV_SHIFT;
    localparam int          REP_RECIP_SHIFT = 32;
    localparam logic [63:0] REP_RECIP      = (64'd1 << REP_RECIP_SHIFT) / REP_DIV_ODD;
    localparam int REP_MAG_W = 15;
    localparam int REP_HI_W  = 29;
    localparam int REP_MD_W  = 23;
    localparam int REP_Q_W   = 12;

    // CORDIC datapath
    localparam int                     REP_CW       = 32;
    localparam logic signed [REP_CW-1:0] REP_CORDIC_K = 32'sd652032874;
    localparam int REP_SC_OVERHEAD = 6;

    // Q1.16 conversion
    localparam int REP_Q16_W     = 18;
    localparam int REP_Q16_SHIFT = 14;
    localparam int REP_Q16_ROUND = 1 << (REP_Q16_SHIFT - 1);
    localparam int REP_Q16_ONE   = 65536;

    // Product path
    localparam int REP_AXP_W      = 28;
    localparam int REP_PROD_W     = 46;
    localparam int REP_SUM_W      = 47;
    localparam int REP_FRAC_SHIFT = 32;
    localparam int REP_TOP_STAGES = 7;

    typedef struct packed {
        logic [REP_ROT_W-1:0] rotation_deg;
        logic [REP_IDX_W-1:0] point_index;
    } rep_in_t;

    typedef struct packed {
        logic signed [REP_PIX_W-1:0] pixel_x;
        logic signed [REP_PIX_W-1:0] pixel_y;
        logic [REP_COLOR_W-1:0]      pixel_color;
    } rep_out_t;

    // atan(2^-i) in Q3.28, rounded to nearest
    function automatic logic signed [REP_CW-1:0] rep_atan_q28(input int idx);
        case (idx)
            0:       return 32'sd210828714;
            1:       return 32'sd124459457;
            2:       return 32'sd65760959;
            3:       return 32'sd33381290;
            4:       return 32'sd16755422;
            5:       return 32'sd8385879;
            6:       return 32'sd4193963;
            7:       return 32'sd2097109;
            8:       return 32'sd1048571;
            9:       return 32'sd524287;
            10:      return 32'sd262144;
            11:      return 32'sd131072;
            default: return REP_CW'(1 << (28 - idx));
        endcase
    endfunction

endpackage

// ===== hw/rtl/rep_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rep_sincos: pipelined cosine and sine of an angle in 1/360 degree
// Folds the angle to [-90, 90] degrees, converts it to Q3.28 radians, runs a
// rotation-mode CORDIC with one iteration per stage and rounds to Q1.16.
// All stages move together on en.
// ----------------------------------------------------------------------------
module rep_sincos
    import rep_pkg::*;
#(
    parameter int ITERATIONS = REP_CORDIC_ITERATIONS
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [REP_ANGLE_W-1:0]      ang,
    output logic signed [REP_Q16_W-1:0] cos_q16,
    output logic signed [REP_Q16_W-1:0] sin_q16
);

    localparam logic signed [REP_CW:0] Q16_MAX = (REP_CW + 1)'(REP_Q16_ONE);
    localparam logic signed [REP_CW:0] Q16_MIN = -(REP_CW + 1)'(REP_Q16_ONE);

    // Stage 1: fold
    logic [REP_MAG_W-1:0] mag_next, mag_reg;
    logic                 zneg_next, zneg1_reg;
    logic                 flip_next, flip1_reg;

    // Stage 2..4: radians conversion
    logic [REP_HI_W-1:0] hi_next, hi2_reg, hi3_reg, hi4_reg;
    logic [REP_MD_W-1:0] md_next, md2_reg, md3_reg;
    logic [REP_Q_W-1:0]  qe_next, qe3_reg;
    logic [REP_Q_W-1:0]  q_next, q4_reg;
    logic [REP_MD_W-1:0] rem;
    logic                zneg2_reg, zneg3_reg, zneg4_reg;
    logic                flip2_reg, flip3_reg, flip4_reg;
    logic [REP_CW-1:0]   zmag;

    // CORDIC stages
    logic signed [REP_CW-1:0] x_reg [ITERATIONS+1];
    logic signed [REP_CW-1:0] y_reg [ITERATIONS+1];
    logic signed [REP_CW-1:0] z_reg [ITERATIONS+1];
    logic                     flip_reg [ITERATIONS+1];

    logic signed [REP_Q16_W-1:0] cos_next, sin_next, cos_reg, sin_reg;

    function automatic logic signed [REP_Q16_W-1:0] to_q16(
        input logic signed [REP_CW-1:0] v,
        input logic                     flip
    );
        logic signed [REP_CW:0] w;
        logic signed [REP_CW:0] r;
        w = {v[REP_CW-1], v};
        if (flip)
            w = -w;
        w = w + (REP_CW + 1)'(REP_Q16_ROUND);
        r = w >>> REP_Q16_SHIFT;
        if (r > Q16_MAX)
            r = Q16_MAX;
        if (r < Q16_MIN)
            r = Q16_MIN;
        return REP_Q16_W'(r);
    endfunction

    always_comb
    begin
        flip_next = 1'b0;
        zneg_next = 1'b0;
        mag_next  = REP_MAG_W'(ang);
        if ((ang > REP_ANGLE_W'(REP_QUARTER_TURN)) && (ang < REP_ANGLE_W'(REP_THREE_QUARTER)))
        begin
            // Flip by half a turn: sine and cosine change sign
            flip_next = 1'b1;
            if (ang >= REP_ANGLE_W'(REP_HALF_TURN))
            begin
                mag_next = REP_MAG_W'(ang - REP_ANGLE_W'(REP_HALF_TURN));
            end
            else
            begin
                mag_next  = REP_MAG_W'(REP_ANGLE_W'(REP_HALF_TURN) - ang);
                zneg_next = 1'b1;
            end
        end
        else if (ang >= REP_ANGLE_W'(REP_THREE_QUARTER))
        begin
            mag_next  = REP_MAG_W'(REP_ANGLE_W'(REP_FULL_TURN) - ang);
            zneg_next = 1'b1;
        end
    end

    // Split PI_Q28 = QUOT * HALF_TURN + REM so only the remainder part divides
    assign hi_next = REP_HI_W'(REP_HI_W'(mag_reg) * REP_HI_W'(REP_PI_QUOT));
    assign md_next = REP_MD_W'((32'(mag_reg) * 32'(REP_PI_REM) + 32'(REP_ROUND_HALF))
                               >> REP_DIV_SHIFT);
    // Reciprocal estimate is exact or one low
    assign qe_next = REP_Q_W'((64'(md2_reg) * REP_RECIP) >> REP_RECIP_SHIFT);
    assign rem     = md3_reg - REP_MD_W'(REP_MD_W'(qe3_reg) * REP_MD_W'(REP_DIV_ODD));
    assign q_next  = qe3_reg + REP_Q_W'(rem >= REP_MD_W'(REP_DIV_ODD));
    assign zmag    = REP_CW'(hi4_reg) + REP_CW'(q4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_next;
            zneg1_reg <= zneg_next;
            flip1_reg <= flip_next;

            hi2_reg   <= hi_next;
            md2_reg   <= md_next;
            zneg2_reg <= zneg1_reg;
            flip2_reg <= flip1_reg;

            hi3_reg   <= hi2_reg;
            md3_reg   <= md2_reg;
            qe3_reg   <= qe_next;
            zneg3_reg <= zneg2_reg;
            flip3_reg <= flip2_reg;

            hi4_reg   <= hi3_reg;
            q4_reg    <= q_next;
            zneg4_reg <= zneg3_reg;
            flip4_reg <= flip3_reg;

            x_reg[0]    <= REP_CORDIC_K;
            y_reg[0]    <= '0;
            z_reg[0]    <= zneg4_reg ? -$signed(zmag) : $signed(zmag);
            flip_reg[0] <= flip4_reg;
        end
    end

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_iter
        localparam logic signed [REP_CW-1:0] ATAN_I = rep_atan_q28(i);
        logic signed [REP_CW-1:0] dx, dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][REP_CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    assign cos_next = to_q16(x_reg[ITERATIONS], flip_reg[ITERATIONS]);
    assign sin_next = to_q16(y_reg[ITERATIONS], flip_reg[ITERATIONS]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_q16 = cos_reg;
    assign sin_q16 = sin_reg;

endmodule

// ===== hw/rtl/rotated_ellipse_point_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_ellipse_point_generator_unit: one screen pixel per request
// Turns a base rotation and a sample number into a point on the right half
// of a rotated ellipse, with the configured color.
// ----------------------------------------------------------------------------
// Usage:
//   Write center, semi-axes, colour and rotation step through cfg_write /
//   cfg_index / cfg_data while no request is in flight.
//   Requests enter on in_valid/in_ready (in_data); pixels leave on
//   out_valid/out_ready (out_data), one pixel per request, in order.
// Throughput: one request per clock while the skid is empty. The two CORDIC pipelines, one stage per
//   iteration, set the depth; every stage is registered.
// Reset: clears all valid bits and loads the register defaults
//   (rotation step 1, everything else 0).
// Stall: the output register holds its pixel; one more pixel lands in a skid
//   register, and while the skid is full in_ready is low and the whole
//   pipeline holds. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rotated_ellipse_point_generator_unit
    import rep_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = REP_CORDIC_ITERATIONS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  rep_in_t                  in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output rep_out_t                 out_data,
    input  logic                     cfg_write,
    input  logic [REP_CFG_IDX_W-1:0] cfg_index,
    input  logic [REP_CFG_W-1:0]     cfg_data
);

    localparam int SC_LATENCY = CORDIC_ITERATIONS + REP_SC_OVERHEAD;
    localparam int DEPTH      = SC_LATENCY + REP_TOP_STAGES;
    localparam logic [REP_SUM_W-1:0] TRUNC_BIAS =
        REP_SUM_W'((64'd1 << REP_FRAC_SHIFT) - 64'd1);

    // Configuration registers
    logic [REP_CENTER_W-1:0] center_x_reg, center_y_reg;
    logic [REP_AXIS_W-1:0]   semi_a_reg, semi_b_reg;
    logic [REP_COLOR_W-1:0]  color_reg;
    logic [REP_STEP_W-1:0]   step_reg;

    // Pipeline control
    logic             advance;
    logic [DEPTH-1:0] valid_reg;

    // Angle stages
    logic [REP_THETA_W-1:0] theta_next, theta_reg;
    logic [REP_ROT_W-1:0]   rot_reg;
    logic [REP_RAW_W-1:0]   ut_next, ur_next, ut_reg, ur_reg;
    logic [REP_ANGLE_W-1:0] ang_t_reg, ang_r_reg;

    // Trig results; the rotation terms are registered alongside the axis products
    logic signed [REP_Q16_W-1:0] cos_t, sin_t, cos_r, sin_r;
    logic signed [REP_Q16_W-1:0] cos_r_reg, sin_r_reg;

    // Product stages
    logic signed [REP_AXP_W-1:0]  act_reg, bst_reg;
    logic signed [REP_PROD_W-1:0] prod_ac_reg, prod_bs_reg, prod_bc_reg, prod_as_reg;
    logic signed [REP_SUM_W-1:0]  sum_x_reg, sum_y_reg;
    logic signed [REP_SUM_W-1:0]  bias_x, bias_y;
    logic [REP_PIX_W-1:0]         off_x_next, off_y_next, off_x_reg, off_y_reg;

    // Output side
    rep_out_t result;
    rep_out_t out_reg, skid_reg;
    logic     out_valid_reg, skid_valid_reg;
    logic     out_take;

    // Reduce a biased angle below five turns to one turn
    function automatic logic [REP_ANGLE_W-1:0] wrap_turn(input logic [REP_RAW_W-1:0] v);
        logic [REP_RAW_W-1:0] r;
        r = v;
        if (v >= REP_RAW_W'(4 * REP_FULL_TURN))
            r = v - REP_RAW_W'(4 * REP_FULL_TURN);
        else if (v >= REP_RAW_W'(3 * REP_FULL_TURN))
            r = v - REP_RAW_W'(3 * REP_FULL_TURN);
        else if (v >= REP_RAW_W'(2 * REP_FULL_TURN))
            r = v - REP_RAW_W'(2 * REP_FULL_TURN);
        else if (v >= REP_RAW_W'(REP_FULL_TURN))
            r = v - REP_RAW_W'(REP_FULL_TURN);
        return REP_ANGLE_W'(r);
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes; drop writes beyond the last register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            semi_a_reg   <= '0;
            semi_b_reg   <= '0;
            color_reg    <= '0;
            step_reg     <= REP_STEP_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REP_REG_CENTER_X:   center_x_reg <= cfg_data[REP_CENTER_W-1:0];
                REP_REG_CENTER_Y:   center_y_reg <= cfg_data[REP_CENTER_W-1:0];
                REP_REG_SEMI_A:     semi_a_reg   <= cfg_data[REP_AXIS_W-1:0];
                REP_REG_SEMI_B:     semi_b_reg   <= cfg_data[REP_AXIS_W-1:0];
                REP_REG_LINE_COLOR: color_reg    <= cfg_data[REP_COLOR_W-1:0];
                REP_REG_ROT_STEP:   step_reg     <= cfg_data[REP_STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline advances unless the skid is full
    // ------------------------------------------------------------------
    assign advance  = !skid_valid_reg;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
    end

    // ------------------------------------------------------------------
    // Angles. Samples past the first quarter skip the left half.
    // Rotation angle is biased by four turns so it never goes negative.
    // ------------------------------------------------------------------
    assign theta_next = (in_data.point_index < REP_IDX_W'(REP_FIRST_SPAN))
                      ? REP_THETA_W'(in_data.point_index)
                      : REP_THETA_W'(in_data.point_index) + REP_THETA_W'(REP_INDEX_SKIP);

    assign ut_next = REP_RAW_W'(theta_reg) * REP_RAW_W'(REP_DEG_UNITS);
    assign ur_next = REP_RAW_W'(REP_UR_BIAS)
                   - REP_RAW_W'(rot_reg) * REP_RAW_W'(REP_DEG_UNITS)
                   - REP_RAW_W'(step_reg) * REP_RAW_W'(theta_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            theta_reg <= theta_next;
            rot_reg   <= in_data.rotation_deg;
            ut_reg    <= ut_next;
            ur_reg    <= ur_next;
            ang_t_reg <= wrap_turn(ut_reg);
            ang_r_reg <= wrap_turn(ur_reg);
        end
    end

    // ------------------------------------------------------------------
    // Cosine and sine of the parameter angle and of the rotation
    // ------------------------------------------------------------------
    rep_sincos #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_sincos_t (
        .clk     (clk),
        .en      (advance),
        .ang     (ang_t_reg),
        .cos_q16 (cos_t),
        .sin_q16 (sin_t)
    );

    rep_sincos #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_sincos_r (
        .clk     (clk),
        .en      (advance),
        .ang     (ang_r_reg),
        .cos_q16 (cos_r),
        .sin_q16 (sin_r)
    );

    // ------------------------------------------------------------------
    // Products at scale 2^32, then truncate toward zero to whole pixels.
    // Keep only the low pixel bits: the coordinate wraps anyway.
    // ------------------------------------------------------------------
    assign bias_x     = sum_x_reg + (sum_x_reg[REP_SUM_W-1] ? $signed(TRUNC_BIAS) : '0);
    assign bias_y     = sum_y_reg + (sum_y_reg[REP_SUM_W-1] ? $signed(TRUNC_BIAS) : '0);
    assign off_x_next = bias_x[REP_FRAC_SHIFT +: REP_PIX_W];
    assign off_y_next = bias_y[REP_FRAC_SHIFT +: REP_PIX_W];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            act_reg     <= $signed({1'b0, semi_a_reg}) * cos_t;
            bst_reg     <= $signed({1'b0, semi_b_reg}) * sin_t;
            cos_r_reg   <= cos_r;
            sin_r_reg   <= sin_r;
            prod_ac_reg <= act_reg * cos_r_reg;
            prod_bs_reg <= bst_reg * sin_r_reg;
            prod_bc_reg <= bst_reg * cos_r_reg;
            prod_as_reg <= act_reg * sin_r_reg;
            sum_x_reg   <= REP_SUM_W'(prod_ac_reg) + REP_SUM_W'(prod_bs_reg);
            sum_y_reg   <= REP_SUM_W'(prod_bc_reg) - REP_SUM_W'(prod_as_reg);
            off_x_reg   <= off_x_next;
            off_y_reg   <= off_y_next;
        end
    end

    // Screen y points down, so the vertical offset is subtracted
    always_comb
    begin
        result.pixel_x     = $signed(REP_PIX_W'(center_x_reg) + off_x_reg);
        result.pixel_y     = $signed(REP_PIX_W'(center_y_reg) - off_y_reg);
        result.pixel_color = color_reg;
    end

    // ------------------------------------------------------------------
    // Output register and skid. A pixel leaving the pipeline goes to the
    // output register if it is free or being taken, else to the skid.
    // While the skid is full, hold the pipeline and drain the skid first.
    // ------------------------------------------------------------------
    assign out_take = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (valid_reg[DEPTH-1])
            begin
                if (!out_valid_reg || out_ready)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (out_take)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (valid_reg[DEPTH-1])
            begin
                if (!out_valid_reg || out_ready)
                    out_reg <= result;
                else
                    skid_reg <= result;
            end
        end
        else if (out_take)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // The skid only fills behind a waiting output pixel
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a pixel while the output register is empty");

    // A full skid freezes every pipeline stage
    a_hold_on_skid: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(valid_reg))
        else $error("pipeline moved while the skid was full");

    // The skid drains only when the output pixel is taken
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(skid_valid_reg) |-> $past(out_valid_reg && out_ready))
        else $error("skid emptied without an output handshake");
`endif

endmodule
